>>> design/toroidal_playfield_store_defines.svh
// assertion macros for the toroidal playfield store
`ifndef TOROIDAL_PLAYFIELD_STORE_DEFINES_SVH
`define TOROIDAL_PLAYFIELD_STORE_DEFINES_SVH

// property must hold at every edge outside reset
`define TPS_ASSERT_ALWAYS(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("toroidal_playfield_store: invariant violated");

// consequent must hold at the edge after the antecedent
`define TPS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("toroidal_playfield_store: sequence violated");

`endif

>>> design/tps_pkg.sv
// shared types and constants of the toroidal playfield store
package tps_pkg;

    localparam int GRID_WIDTH_DEF  = 80;
    localparam int GRID_HEIGHT_DEF = 25;
    localparam int CELL_BITS_DEF   = 32;

    localparam int FUNC_BITS  = 3;
    localparam int COORD_BITS = 32;
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int BYTE_BITS  = 8;

    // s_tdata layout
    localparam int POS_X_LSB    = 0;
    localparam int POS_Y_LSB    = 32;
    localparam int OFF_X_LSB    = 64;
    localparam int OFF_Y_LSB    = 96;
    localparam int CELL_VAL_LSB = 128;
    localparam int TEXT_LSB     = 160;
    localparam int IN_DATA_BITS = 168;

    // m_tdata layout
    localparam int READ_VAL_LSB  = 0;
    localparam int NEW_X_LSB     = 32;
    localparam int NEW_Y_LSB     = 64;
    localparam int LOAD_FULL_BIT = 96;
    localparam int OUT_DATA_BITS = 104;

    // bits retired per cycle by the modulo unit
    localparam int MOD_STEP = 4;

    localparam logic [FUNC_BITS-1:0] FUNC_READ       = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_WRITE      = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_WRAP       = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_START_LOAD = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD_BYTE  = 3'd4;

    localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_ADDR,
        ST_MEM,
        ST_OUT
    } ctrl_state_t;

endpackage

>>> design/toroidal_playfield_store.sv
// Toroidal playfield store: a GRID_WIDTH x GRID_HEIGHT grid of cells on a torus.
// One request on s_* (operation code on s_tuser, operands on s_tdata) gives
// exactly one result on m_* (read value, new position, load-full flag).
// Requests are handled one at a time; s_tready drops from accept to result.
// Read and write wrap (pos + off) through two iterative modulo units that
// retire 4 bits per cycle, then form the address with one multiply and
// touch the memory once. Cardinal wrap uses the modulo units only.
// Non-cardinal wrap of an out-of-range position walks back one step per
// cycle. A text byte passes through the address and memory states; start
// load and unused codes go straight to the output state.
// After reset a sweep writes a space into every cell, and s_tready stays
// low until it ends.
// A result sits in the output register until m_tready; the next request is
// accepted meanwhile and waits finished until the register frees up.
`include "toroidal_playfield_store_defines.svh"

module toroidal_playfield_store import tps_pkg::*; #(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int CELL_BITS   = CELL_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pos_x, pos_y, off_x, off_y, cell_value, text_byte
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // func
    input  logic [FUNC_BITS-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // read_value, new_x, new_y, load_full, zero padding
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int RXW   = $clog2(GRID_WIDTH);
    localparam int RYW   = $clog2(GRID_HEIGHT);
    localparam int COLW  = $clog2(GRID_WIDTH + 1);
    localparam int ROWW  = $clog2(GRID_HEIGHT + 1);
    localparam int PADW  = OUT_DATA_BITS - LOAD_FULL_BIT - 1;

    ctrl_state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] s_pos_x, s_pos_y, s_off_x, s_off_y, s_cell;
    logic [BYTE_BITS-1:0]         s_byte;
    logic [FUNC_BITS-1:0]         s_func;
    logic                         s_card, s_accept, s_ready_int;

    logic [FUNC_BITS-1:0]  func_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg, cval_reg;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  card_reg;

    logic [SUM_BITS-1:0] modx_in, mody_in;
    logic                mod_start, modx_busy, mody_busy;
    logic [RXW-1:0]      rx;
    logic [RYW-1:0]      ry;

    logic                  walk_start, walk_busy;
    logic [COORD_BITS-1:0] walk_x, walk_y;

    logic [COLW-1:0] ld_col_reg, ld_col_next, mul_col;
    logic [ROWW-1:0] ld_row_reg, ld_row_next, mul_row;
    logic            ld_cr_reg, ld_cr_next, ld_store;

    logic [AW-1:0]        addr_reg, idx;
    logic                 we_reg, mem_re, mem_we, mem_clearing;
    logic [CELL_BITS-1:0] wdata_reg, mem_rdata;
    logic [63:0]          cell_wide, byte_wide, rd_wide;

    logic                     out_load, m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    logic [COORD_BITS-1:0]    o_read, o_x, o_y;
    logic                     o_full;

    assign s_pos_x = s_tdata[POS_X_LSB +: COORD_BITS];
    assign s_pos_y = s_tdata[POS_Y_LSB +: COORD_BITS];
    assign s_off_x = s_tdata[OFF_X_LSB +: COORD_BITS];
    assign s_off_y = s_tdata[OFF_Y_LSB +: COORD_BITS];
    assign s_cell  = s_tdata[CELL_VAL_LSB +: COORD_BITS];
    assign s_byte  = s_tdata[TEXT_LSB +: BYTE_BITS];
    assign s_func  = s_tuser;

    assign s_card = ((s_off_x == 32'sd0) && ((s_off_y == 32'sd1) || (s_off_y == -32'sd1)))
                 || ((s_off_y == 32'sd0) && ((s_off_x == 32'sd1) || (s_off_x == -32'sd1)));
    assign s_accept = s_tvalid && s_ready_int;

    // wrap reduces the bare position, read and write reduce position plus offset
    always_comb begin
        if (s_func == FUNC_WRAP) begin
            modx_in = {s_pos_x[COORD_BITS-1], s_pos_x};
            mody_in = {s_pos_y[COORD_BITS-1], s_pos_y};
        end else begin
            modx_in = {s_pos_x[COORD_BITS-1], s_pos_x} + {s_off_x[COORD_BITS-1], s_off_x};
            mody_in = {s_pos_y[COORD_BITS-1], s_pos_y} + {s_off_y[COORD_BITS-1], s_off_y};
        end
    end

    tps_emod #(.MODULUS(GRID_WIDTH)) u_modx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .operand (modx_in),
        .busy    (modx_busy),
        .rem     (rx)
    );

    tps_emod #(.MODULUS(GRID_HEIGHT)) u_mody (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .operand (mody_in),
        .busy    (mody_busy),
        .rem     (ry)
    );

    tps_walk #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .pos_x   (s_pos_x),
        .pos_y   (s_pos_y),
        .dlt_x   (s_off_x),
        .dlt_y   (s_off_y),
        .busy    (walk_busy),
        .new_x   (walk_x),
        .new_y   (walk_y)
    );

    tps_grid_mem #(.DEPTH(CELLS), .CELL_BITS(CELL_BITS)) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (mem_re),
        .wr_en    (mem_we),
        .addr     (addr_reg),
        .wdata    (wdata_reg),
        .rdata    (mem_rdata),
        .clearing (mem_clearing)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_func)
                        FUNC_READ, FUNC_WRITE: state_next = ST_MOD;
                        FUNC_WRAP:             state_next = s_card ? ST_MOD : ST_WALK;
                        FUNC_LOAD_BYTE:        state_next = ST_ADDR;
                        default:               state_next = ST_OUT;
                    endcase
                end
            end
            ST_MOD: begin
                if (!modx_busy) begin
                    state_next = (func_reg == FUNC_WRAP) ? ST_OUT : ST_ADDR;
                end
            end
            ST_WALK: begin
                if (!walk_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_ADDR: state_next = ST_MEM;
            ST_MEM:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready_int = (state_reg == ST_IDLE) && !mem_clearing;
        mod_start   = 1'b0;
        walk_start  = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_ready_int) begin
                    mod_start  = (s_func == FUNC_READ) || (s_func == FUNC_WRITE)
                              || ((s_func == FUNC_WRAP) && s_card);
                    walk_start = (s_func == FUNC_WRAP) && !s_card;
                end
            end
            ST_MEM: begin
                mem_re = (func_reg == FUNC_READ);
                mem_we = we_reg;
            end
            ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // text loader cursor
    always_comb begin
        ld_col_next = ld_col_reg;
        ld_row_next = ld_row_reg;
        ld_cr_next  = ld_cr_reg;
        ld_store    = 1'b0;
        if (s_accept && (s_func == FUNC_START_LOAD)) begin
            ld_col_next = '0;
            ld_row_next = '0;
            ld_cr_next  = 1'b0;
        end else if ((state_reg == ST_ADDR) && (func_reg == FUNC_LOAD_BYTE)
                     && (byte_reg != CHAR_NUL)) begin
            ld_cr_next = 1'b0;
            // lf right after cr is part of the same line end
            if (!(ld_cr_reg && (byte_reg == CHAR_LF))) begin
                if ((byte_reg == CHAR_CR) || (byte_reg == CHAR_LF)) begin
                    ld_col_next = '0;
                    if (ld_row_reg < ROWW'(GRID_HEIGHT)) begin
                        ld_row_next = ld_row_reg + ROWW'(1);
                    end
                    ld_cr_next = (byte_reg == CHAR_CR);
                end else if (ld_col_reg < COLW'(GRID_WIDTH)) begin
                    ld_store    = (ld_row_reg < ROWW'(GRID_HEIGHT));
                    ld_col_next = ld_col_reg + COLW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_col_reg <= '0;
            ld_row_reg <= '0;
            ld_cr_reg  <= 1'b0;
        end else begin
            ld_col_reg <= ld_col_next;
            ld_row_reg <= ld_row_next;
            ld_cr_reg  <= ld_cr_next;
        end
    end

    // cell address: wrapped access point or load cursor
    always_comb begin
        if (func_reg == FUNC_LOAD_BYTE) begin
            mul_row = ld_row_reg;
            mul_col = ld_col_reg;
        end else begin
            mul_row = ROWW'(ry);
            mul_col = COLW'(rx);
        end
        idx = AW'(AW'(mul_row) * AW'(GRID_WIDTH) + AW'(mul_col));
    end

    assign cell_wide = {32'd0, cval_reg};
    assign byte_wide = {56'd0, byte_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            we_reg <= 1'b0;
        end else if (state_reg == ST_ADDR) begin
            we_reg <= (func_reg == FUNC_WRITE) || ld_store;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_func;
            px_reg   <= s_pos_x;
            py_reg   <= s_pos_y;
            cval_reg <= s_cell;
            byte_reg <= s_byte;
            card_reg <= s_card;
        end
        if (state_reg == ST_ADDR) begin
            addr_reg  <= idx;
            wdata_reg <= (func_reg == FUNC_WRITE) ? cell_wide[CELL_BITS-1:0]
                                                  : byte_wide[CELL_BITS-1:0];
        end
    end

    // result fields
    assign rd_wide = 64'($signed(mem_rdata));

    always_comb begin
        o_read = '0;
        o_x    = px_reg;
        o_y    = py_reg;
        if (func_reg == FUNC_READ) begin
            o_read = rd_wide[COORD_BITS-1:0];
        end
        if (func_reg == FUNC_WRAP) begin
            o_x = card_reg ? COORD_BITS'(rx) : walk_x;
            o_y = card_reg ? COORD_BITS'(ry) : walk_y;
        end
        o_full = (ld_row_reg >= ROWW'(GRID_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {PADW'(0), o_full, o_y, o_x, o_read};
        end
    end

    assign s_tready = s_ready_int;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TPS_ASSERT_ALWAYS(a_no_accept_while_clearing, aclk, aresetn, !(mem_clearing && s_ready_int))
    `TPS_ASSERT_ALWAYS(a_mod_lockstep, aclk, aresetn, modx_busy == mody_busy)
    `TPS_ASSERT_ALWAYS(a_cursor_bounds, aclk, aresetn, (ld_col_reg <= COLW'(GRID_WIDTH)) && (ld_row_reg <= ROWW'(GRID_HEIGHT)))
    `TPS_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_ready_int, (state_reg != ST_IDLE) && !s_ready_int)

endmodule

>>> design/tps_emod.sv
// iterative euclidean modulo of a signed sum by a constant modulus
module tps_emod import tps_pkg::*; #(
    parameter int MODULUS = GRID_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [SUM_BITS-1:0]          operand,
    output logic                         busy,
    output logic [$clog2(MODULUS)-1:0]   rem
);

    localparam int RW    = $clog2(MODULUS);
    localparam int UW    = SUM_BITS + 1;
    localparam int NSTEP = (UW + MOD_STEP - 1) / MOD_STEP;
    localparam int PW    = NSTEP * MOD_STEP;
    localparam int CW    = $clog2(NSTEP + 1);
    localparam logic [63:0] SPAN   = 64'd1 << (SUM_BITS - 1);
    // smallest multiple of the modulus that lifts any operand to zero or above
    localparam logic [63:0] OFFSET =
        ((SPAN + 64'(MODULUS) - 64'd1) / 64'(MODULUS)) * 64'(MODULUS);

    logic [UW-1:0] lifted;
    logic [PW-1:0] sh_reg, sh_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    assign lifted = UW'({operand[SUM_BITS-1], operand}) + UW'(OFFSET);

    // restoring remainder, msb first
    always_comb begin
        logic [RW:0]   trial;
        logic [RW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < MOD_STEP; i++) begin
            trial = {r, sh_reg[PW-1-i]};
            if (trial >= (RW+1)'(MODULUS)) begin
                trial = trial - (RW+1)'(MODULUS);
            end
            r = trial[RW-1:0];
        end
        rem_next = r;
        sh_next  = sh_reg << MOD_STEP;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            cnt_next  = CW'(NSTEP);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= PW'(lifted);
            rem_reg <= '0;
        end else if (busy_reg) begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

>>> design/tps_walk.sv
// backward walk of a position to the far grid edge for non-cardinal deltas
module tps_walk import tps_pkg::*; #(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [COORD_BITS-1:0] dlt_x,
    input  logic [COORD_BITS-1:0] dlt_y,
    output logic                  busy,
    output logic [COORD_BITS-1:0] new_x,
    output logic [COORD_BITS-1:0] new_y
);

    logic [SUM_BITS-1:0]   cx_reg, cy_reg, cand_x, cand_y, start_x, start_y;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic                  busy_reg, busy_next;

    function automatic logic in_grid(logic [SUM_BITS-1:0] x, logic [SUM_BITS-1:0] y);
        in_grid = !x[SUM_BITS-1] && (x < SUM_BITS'(GRID_WIDTH))
               && !y[SUM_BITS-1] && (y < SUM_BITS'(GRID_HEIGHT));
    endfunction

    assign start_x = {pos_x[COORD_BITS-1], pos_x};
    assign start_y = {pos_y[COORD_BITS-1], pos_y};
    assign cand_x  = cx_reg - {dx_reg[COORD_BITS-1], dx_reg};
    assign cand_y  = cy_reg - {dy_reg[COORD_BITS-1], dy_reg};

    always_comb begin
        busy_next = busy_reg;
        if (start) begin
            busy_next = !in_grid(start_x, start_y);
        end else if (busy_reg) begin
            busy_next = in_grid(cand_x, cand_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // keep the last in-range point, stop at the first one outside
    always_ff @(posedge aclk) begin
        if (start) begin
            cx_reg <= start_x;
            cy_reg <= start_y;
            dx_reg <= dlt_x;
            dy_reg <= dlt_y;
        end else if (busy_reg && in_grid(cand_x, cand_y)) begin
            cx_reg <= cand_x;
            cy_reg <= cand_y;
        end
    end

    assign busy  = busy_reg;
    assign new_x = cx_reg[COORD_BITS-1:0];
    assign new_y = cy_reg[COORD_BITS-1:0];

endmodule

>>> design/tps_grid_mem.sv
// single-port cell memory with a space-filling sweep after reset
module tps_grid_mem import tps_pkg::*; #(
    parameter int DEPTH     = GRID_WIDTH_DEF * GRID_HEIGHT_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [CELL_BITS-1:0]     wdata,
    output logic [CELL_BITS-1:0]     rdata,
    output logic                     clearing
);

    localparam int AW = $clog2(DEPTH);

    logic [CELL_BITS-1:0] mem [DEPTH];
    logic [CELL_BITS-1:0] rdata_reg;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 clr_reg, clr_next;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_next      = clr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            clr_next      = (clr_addr_reg != AW'(DEPTH - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_addr_reg] <= CELL_BITS'(CHAR_SPACE);
        end else if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_reg;

endmodule

>>> tb/tb_toroidal_playfield_store.sv
// self-checking testbench for the toroidal playfield store
module tb_toroidal_playfield_store import tps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W       = GRID_WIDTH_DEF;
    localparam int GRID_H       = GRID_HEIGHT_DEF;
    localparam int RESET_CYCLES = 12;
    localparam int TARGET_ITEMS = 1150;
    localparam int TAIL_ITEMS   = 120;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int FUNC_TOP     = (1 << FUNC_BITS) - 1;

    typedef struct {
        logic [FUNC_BITS-1:0]   func;
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic signed [31:0]     off_x;
        logic signed [31:0]     off_y;
        logic signed [31:0]     cell_value;
        logic [BYTE_BITS-1:0]   text_byte;
        bit                     drain_point;
    } request_t;

    typedef struct {
        logic signed [31:0] read_value;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic               load_full;
    } result_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [FUNC_BITS-1:0]     s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    toroidal_playfield_store u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the playfield and the text loader
    logic signed [31:0] playfield [GRID_W*GRID_H];
    int                 load_col;
    int                 load_row;
    bit                 cr_seen;

    request_t requests_to_send [$];
    result_t  results_due [$];
    request_t on_bus;
    int       useful_items;
    int       mismatches;
    int       results_seen;
    int       cycle_count;
    bit       no_idle;

    function automatic longint emod(longint a, longint m);
        longint r;
        r = a % m;
        return (r < 0) ? r + m : r;
    endfunction

    function automatic bit on_grid(longint x, longint y);
        return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
    endfunction

    function automatic int cell_at(longint x, longint y);
        return int'(emod(y, GRID_H) * GRID_W + emod(x, GRID_W));
    endfunction

    function void close_line();
        load_col = 0;
        if (load_row < GRID_H)
            load_row++;
    endfunction

    function void feed_text(logic [BYTE_BITS-1:0] b);
        if (b == CHAR_NUL)
            return;
        if (cr_seen) begin
            cr_seen = 1'b0;
            // lf right after cr belongs to the same line end
            if (b == CHAR_LF)
                return;
        end
        if (b == CHAR_CR) begin
            close_line();
            cr_seen = 1'b1;
        end else if (b == CHAR_LF) begin
            close_line();
        end else if (load_col < GRID_W) begin
            if (load_row < GRID_H)
                playfield[load_row*GRID_W + load_col] = {24'd0, b};
            load_col++;
        end
    endfunction

    // applies one request to the shadow playfield and returns its result
    function result_t compute_playfield_result(request_t r);
        result_t res;
        longint  nx, ny, dx, dy;
        bit      cardinal;
        nx = r.pos_x;
        ny = r.pos_y;
        dx = r.off_x;
        dy = r.off_y;
        res.read_value = '0;
        case (r.func)
            FUNC_READ:
                res.read_value = playfield[cell_at(nx + dx, ny + dy)];
            FUNC_WRITE:
                playfield[cell_at(nx + dx, ny + dy)] = r.cell_value;
            FUNC_WRAP: begin
                cardinal = (dx == 0 && (dy == 1 || dy == -1)) ||
                           (dy == 0 && (dx == 1 || dx == -1));
                if (cardinal) begin
                    nx = emod(nx, GRID_W);
                    ny = emod(ny, GRID_H);
                end else if (!on_grid(nx, ny)) begin
                    // walk back across the grid, land on its far edge
                    do begin
                        nx -= dx;
                        ny -= dy;
                    end while (on_grid(nx, ny));
                    nx += dx;
                    ny += dy;
                end
            end
            FUNC_START_LOAD: begin
                load_col = 0;
                load_row = 0;
                cr_seen  = 1'b0;
            end
            FUNC_LOAD_BYTE:
                feed_text(r.text_byte);
            default: ;
        endcase
        res.new_x     = nx[31:0];
        res.new_y     = ny[31:0];
        res.load_full = (load_row >= GRID_H);
        return res;
    endfunction

    function void add_request(logic [FUNC_BITS-1:0] f, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] ox,
                              logic signed [31:0] oy, logic signed [31:0] cv,
                              logic [BYTE_BITS-1:0] tb);
        request_t r;
        r = '{f, px, py, ox, oy, cv, tb, 1'b0};
        requests_to_send.push_back(r);
        if (f <= FUNC_LOAD_BYTE && !(f == FUNC_LOAD_BYTE && tb == CHAR_NUL))
            useful_items++;
    endfunction

    function void add_drain_point();
        request_t r;
        r = '{default: '0};
        r.drain_point = 1'b1;
        requests_to_send.push_back(r);
    endfunction

    function void add_text(logic [BYTE_BITS-1:0] b);
        add_request(FUNC_LOAD_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom, b);
    endfunction

    // mostly near the grid, now and then anywhere or at the extremes
    function automatic logic signed [31:0] pick_coord(int span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return int'($urandom_range(0, 3 * span)) - span;
        endcase
    endfunction

    // request driver
    always @(posedge aclk) begin : driver
        int gap_left;
        int calm_left;
        int pick;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            gap_left  = 0;
            calm_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                results_due.push_back(compute_playfield_result(on_bus));
            no_idle <= (requests_to_send.size() < TAIL_ITEMS);
            if (!s_tvalid || s_tready) begin
                pick = $urandom_range(0, 99);
                if (requests_to_send.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (requests_to_send[0].drain_point) begin
                    // hold back until every result is in
                    s_tvalid <= 1'b0;
                    if (results_due.size() == 0)
                        void'(requests_to_send.pop_front());
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (!no_idle && calm_left == 0 && pick < 20) begin
                    gap_left = $urandom_range(1, 9) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    if (calm_left > 0)
                        calm_left--;
                    else if (pick == 99)
                        calm_left = $urandom_range(60, 200);
                    on_bus = requests_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.func;
                    s_tdata  <= {on_bus.text_byte, on_bus.cell_value, on_bus.off_y,
                                 on_bus.off_x, on_bus.pos_y, on_bus.pos_x};
                end
            end
        end
    end

    // result ready with random stalls and one long hold-off
    always @(posedge aclk) begin : receiver
        int stall_left;
        int calm_left;
        int hold_left;
        bit hold_done;
        int pick;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && calm_left == 0 && pick < 20) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                if (calm_left > 0)
                    calm_left--;
                else if (pick == 99)
                    calm_left = $urandom_range(60, 200);
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            got.read_value = m_tdata[READ_VAL_LSB +: COORD_BITS];
            got.new_x      = m_tdata[NEW_X_LSB +: COORD_BITS];
            got.new_y      = m_tdata[NEW_Y_LSB +: COORD_BITS];
            got.load_full  = m_tdata[LOAD_FULL_BIT];
            if (results_due.size() == 0) begin
                $error("unexpected result: read_value %0d new_x %0d new_y %0d",
                       got.read_value, got.new_x, got.new_y);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got.read_value !== want.read_value) begin
                    $error("read_value mismatch: expected %0d, got %0d",
                           want.read_value, got.read_value);
                    mismatches++;
                end
                if (got.new_x !== want.new_x) begin
                    $error("new_x mismatch: expected %0d, got %0d", want.new_x, got.new_x);
                    mismatches++;
                end
                if (got.new_y !== want.new_y) begin
                    $error("new_y mismatch: expected %0d, got %0d", want.new_y, got.new_y);
                    mismatches++;
                end
                if (got.load_full !== want.load_full) begin
                    $error("load_full mismatch: expected %0d, got %0d",
                           want.load_full, got.load_full);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [31:0] dx, dy;
        int                 pick;
        bit                 dense;
        bit                 mid_drain;
        useful_items = 0;
        mismatches   = 0;
        results_seen = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        load_col     = 0;
        load_row     = 0;
        cr_seen      = 1'b0;
        mid_drain    = 1'b0;
        foreach (playfield[i])
            playfield[i] = {24'd0, CHAR_SPACE};

        // directed part: extremes, every operation, loader corner cases
        add_request(FUNC_READ, 0, 0, 0, 0, $urandom, BYTE_BITS'($urandom));
        add_request(FUNC_WRITE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh8000_0000, 8'hff);
        add_request(FUNC_READ, 0, 16, 0, 0, 0, 8'h00);
        add_request(FUNC_WRITE, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh7fff_ffff, 32'sh7fff_ffff, 8'h00);
        add_request(FUNC_READ, -2, -2, 0, 0, 0, 8'h00);
        add_request(FUNC_WRAP, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0, 0, 8'h00);
        add_request(FUNC_WRAP, 85, -1, 0, -1, 0, 8'h00);
        add_request(FUNC_WRAP, 10, 10, 1, 1, 0, 8'h00);
        add_request(FUNC_WRAP, 81, 12, 2, 1, 0, 8'h00);
        add_request(FUNC_WRAP, -1, 5, -1, 1, 0, 8'h00);
        add_request(FUNC_WRAP, -5, 100, 0, 0, 0, 8'h00);
        add_request(FUNC_WRAP, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh8000_0000, 0, 8'h00);
        add_request(FUNC_START_LOAD, 3, 4, 5, 6, 7, 8'h41);
        add_text(8'h41);
        add_text(CHAR_NUL);
        add_text(CHAR_CR);
        add_text(CHAR_LF);
        add_text(8'h42);
        add_text(CHAR_LF);
        add_text(CHAR_CR);
        add_text(CHAR_CR);
        add_text(8'hff);
        add_request(FUNC_READ, 0, 1, 0, 0, 0, 8'h00);
        add_request(FUNC_READ, 0, 4, 0, 0, 0, 8'h00);
        for (int f = FUNC_LOAD_BYTE + 1; f <= FUNC_TOP; f++)
            add_request(FUNC_BITS'(f), $urandom, $urandom, $urandom, $urandom, $urandom,
                        BYTE_BITS'($urandom));
        add_drain_point();

        // random part
        while (useful_items < TARGET_ITEMS) begin
            if (!mid_drain && useful_items >= TARGET_ITEMS / 2) begin
                mid_drain = 1'b1;
                add_drain_point();
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_request(FUNC_WRITE, pick_coord(GRID_W), pick_coord(GRID_H),
                            pick_coord(GRID_W), pick_coord(GRID_H),
                            $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255),
                            BYTE_BITS'($urandom));
            end else if (pick < 57) begin
                add_request(FUNC_READ, pick_coord(GRID_W), pick_coord(GRID_H),
                            pick_coord(GRID_W), pick_coord(GRID_H), $urandom,
                            BYTE_BITS'($urandom));
            end else if (pick < 79) begin
                if ($urandom_range(0, 1)) begin
                    dx = 0;
                    dy = 0;
                    case ($urandom_range(0, 3))
                        0: dx = 1;
                        1: dx = -1;
                        2: dy = 1;
                        default: dy = -1;
                    endcase
                    add_request(FUNC_WRAP, pick_coord(GRID_W), pick_coord(GRID_H),
                                dx, dy, $urandom, BYTE_BITS'($urandom));
                end else if ($urandom_range(0, 6) == 0) begin
                    add_request(FUNC_WRAP, $urandom, $urandom, $urandom, $urandom,
                                $urandom, BYTE_BITS'($urandom));
                end else begin
                    add_request(FUNC_WRAP, int'($urandom_range(0, 99)) - 10,
                                int'($urandom_range(0, 44)) - 10,
                                int'($urandom_range(0, 6)) - 3,
                                int'($urandom_range(0, 6)) - 3, $urandom,
                                BYTE_BITS'($urandom));
                end
            end else if (pick < 82) begin
                add_request(FUNC_BITS'($urandom_range(FUNC_LOAD_BYTE + 1, FUNC_TOP)),
                            $urandom, $urandom, $urandom, $urandom, $urandom,
                            BYTE_BITS'($urandom));
            end else if (pick < 90) begin
                // stray text byte outside a load session
                add_text(BYTE_BITS'($urandom_range(0, 255)));
            end else if (pick < 91) begin
                // a load session, either many short lines or a few overlong ones
                add_request(FUNC_START_LOAD, $urandom, $urandom, $urandom, $urandom,
                            $urandom, BYTE_BITS'($urandom));
                dense = 1'($urandom_range(0, 1));
                repeat ($urandom_range(30, 120)) begin
                    if ($urandom_range(0, dense ? 2 : 59) == 0) begin
                        case ($urandom_range(0, 2))
                            0: add_text(CHAR_CR);
                            1: add_text(CHAR_LF);
                            default: begin
                                add_text(CHAR_CR);
                                add_text(CHAR_LF);
                            end
                        endcase
                    end else if ($urandom_range(0, 9) == 0) begin
                        add_text(BYTE_BITS'($urandom_range(0, 255)));
                    end else begin
                        add_text(BYTE_BITS'($urandom_range(33, 126)));
                    end
                end
            end else begin
                add_request(FUNC_READ, int'($urandom_range(0, GRID_W - 1)),
                            int'($urandom_range(0, GRID_H - 1)), 0, 0, $urandom,
                            BYTE_BITS'($urandom));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
